### src/wom_pkg.sv
`timescale 1ns / 1ps

package wom_pkg;

  // Default sizes of the statistics store.
  localparam int STATE_DIM_DEF   = 4;
  localparam int TIME_POINTS_DEF = 64;

  // Fixed widths of the sample and the state.
  localparam int NUM_VAL  = 4;
  localparam int DATA_W   = 32;
  localparam int CUM_W    = 48;
  localparam int SUM_W    = 64;
  localparam int QUOT_W   = 33;
  localparam int SHIFT_W  = 64;
  localparam int ITER_W   = 6;

  // Iteration counts of the shared divider.
  localparam logic [ITER_W-1:0] MEAN_ITERS = 6'd33;
  localparam logic [ITER_W-1:0] READ_ITERS = 6'd32;

  localparam logic [CUM_W-1:0]  CUM_MAX    = '1;
  localparam logic [SUM_W-1:0]  SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] OUT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] OUT_NEG_MAX = 32'h8000_0000;

  localparam int QUEUE_DEPTH = 2;

  // Operation codes on the mode input.
  typedef enum logic [1:0] {
    MODE_ACC  = 2'd0,
    MODE_CLR  = 2'd1,
    MODE_RD   = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // Classified command kinds held in the queue.
  typedef enum logic [1:0] {
    CMD_ACC = 2'd0,
    CMD_CLR = 2'd1,
    CMD_RD  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                       kind;
    logic                            in_range;
    logic [5:0]                      time_index;
    logic [1:0]                      row_index;
    logic [DATA_W-1:0]               weight;
    logic [NUM_VAL-1:0][DATA_W-1:0]  value;
    logic                            last;
  } cmd_t;

  // Control from the execution side back to the front.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_DIV,
    ST_ACC_WAIT,
    ST_ACC_WR,
    ST_CV_A,
    ST_CV_B,
    ST_CV_C,
    ST_COMMIT,
    ST_RD_MEAN,
    ST_RD_ADDR,
    ST_RD_CHK,
    ST_RD_WAIT,
    ST_EMIT
  } back_state_e;

endpackage

### src/wom_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The partial remainder starts
// at rem_init_i and the dividend bits are shifted in MSB first from bits_i.
module wom_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [wom_pkg::CUM_W-1:0]           rem_init_i,
  input  logic [wom_pkg::SHIFT_W-1:0]         bits_i,
  input  logic [wom_pkg::ITER_W-1:0]          iters_i,
  input  logic [wom_pkg::CUM_W-1:0]           divisor_i,
  output logic                                done_o,
  output logic [wom_pkg::QUOT_W-1:0]          quot_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [wom_pkg::ITER_W-1:0]          cnt_q;
  logic [wom_pkg::CUM_W-1:0]           rem_q;
  logic [wom_pkg::SHIFT_W-1:0]         sh_q;
  logic [wom_pkg::QUOT_W-1:0]          quo_q;
  logic [wom_pkg::CUM_W-1:0]           dvs_q;
  logic [wom_pkg::CUM_W:0]             trial;
  logic [wom_pkg::CUM_W:0]             rem_nx;
  logic                                ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial  = {rem_q, sh_q[wom_pkg::SHIFT_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_nx = ge ? (trial - {1'b0, dvs_q}) : trial;
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == wom_pkg::ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      sh_q  <= bits_i;
      quo_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx[wom_pkg::CUM_W-1:0];
      sh_q  <= {sh_q[wom_pkg::SHIFT_W-2:0], 1'b0};
      quo_q <= {quo_q[wom_pkg::QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### src/wom_front.sv
`timescale 1ns / 1ps

// Accepts commands, drops those that do nothing, and queues the rest.
module wom_front #(
  parameter int TIME_POINTS = wom_pkg::TIME_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [5:0]                  time_index_i,
  input  logic [1:0]                  row_index_i,
  input  logic [31:0]                 weight_i,
  input  logic signed [31:0]          value_0_i,
  input  logic signed [31:0]          value_1_i,
  input  logic signed [31:0]          value_2_i,
  input  logic signed [31:0]          value_3_i,
  input  logic                        last_of_sample_i,
  input  wom_pkg::back_ctl_t          ctl_i,
  output logic                        q_valid_o,
  output wom_pkg::cmd_t               q_cmd_o
);

  localparam int PW = (wom_pkg::QUEUE_DEPTH > 1) ? $clog2(wom_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(wom_pkg::QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(wom_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(wom_pkg::QUEUE_DEPTH - 1);

  wom_pkg::cmd_t   fifo_q [wom_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [NW-1:0]   cnt_q;
  logic            keep;
  logic            push;
  wom_pkg::cmd_t   cmd;

  // Classify the incoming transfer.
  always_comb begin
    cmd            = '0;
    keep           = 1'b0;
    cmd.in_range   = int'(time_index_i) < TIME_POINTS;
    cmd.time_index = time_index_i;
    cmd.row_index  = row_index_i;
    cmd.weight     = weight_i;
    cmd.value      = {value_3_i, value_2_i, value_1_i, value_0_i};
    cmd.last       = last_of_sample_i;
    cmd.kind       = wom_pkg::CMD_ACC;
    case (mode_i)
      wom_pkg::MODE_ACC: begin
        keep = weight_i != '0;
      end
      wom_pkg::MODE_CLR: begin
        keep     = 1'b1;
        cmd.kind = wom_pkg::CMD_CLR;
      end
      wom_pkg::MODE_RD: begin
        keep     = 1'b1;
        cmd.kind = wom_pkg::CMD_RD;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy = (cnt_q == FULL_CNT) || ctl_i.clearing;
  assign push = start && !busy && keep;

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (ctl_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + NW'(push) - NW'(ctl_i.pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_cmd_o   = fifo_q[rd_ptr_q];

endmodule

### src/wom_back.sv
`timescale 1ns / 1ps

// Executes queued commands against the mean and covariance stores.
module wom_back #(
  parameter int STATE_DIM   = wom_pkg::STATE_DIM_DEF,
  parameter int TIME_POINTS = wom_pkg::TIME_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  wom_pkg::cmd_t               q_cmd_i,
  output wom_pkg::back_ctl_t          ctl_o,
  output logic                        valid_o,
  output logic signed [31:0]          mean_value_o,
  output logic signed [31:0]          cov_0_o,
  output logic signed [31:0]          cov_1_o,
  output logic signed [31:0]          cov_2_o,
  output logic signed [31:0]          cov_3_o,
  output logic                        no_weight_o
);

  localparam int MD   = TIME_POINTS * STATE_DIM;
  localparam int CD   = MD * STATE_DIM;
  localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int CLW  = $clog2(CD + 1);
  localparam int IW   = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int CW   = $clog2(STATE_DIM + 1);
  localparam int NCOL = (STATE_DIM < wom_pkg::NUM_VAL) ? STATE_DIM : wom_pkg::NUM_VAL;
  localparam logic [CW-1:0]  LAST_IDX = CW'(STATE_DIM - 1);
  localparam logic [CW-1:0]  LAST_COL = CW'(NCOL - 1);
  localparam logic [CLW-1:0] LAST_CLR = CLW'(CD - 1);
  localparam logic [CLW-1:0] MEAN_END = CLW'(MD);

  wom_pkg::back_state_e state_q, state_d;
  wom_pkg::cmd_t        cmd_q;
  logic [CW-1:0]        r_q;
  logic [CW-1:0]        c_q;
  logic [CLW-1:0]       clr_q;
  logic [wom_pkg::CUM_W-1:0] cum_q;
  logic                 valid_q;

  // Storage.
  logic [31:0]          mean_mem [MD];
  logic [63:0]          cov_mem  [CD];
  logic [31:0]          mean_rdata_q;
  logic [63:0]          cov_rdata_q;
  logic                 mean_re, mean_we, cov_re, cov_we;
  logic [MAW-1:0]       mean_addr, mean_waddr;
  logic [CAW-1:0]       cov_addr, cov_waddr;
  logic [31:0]          mean_wdata;
  logic [63:0]          cov_wdata;

  // Datapath registers.
  logic [63:0]          pw_q;
  logic signed [31:0]   mv_q;
  logic signed [32:0]   dlt_q [STATE_DIM];
  logic signed [31:0]   nm_q  [STATE_DIM];
  logic [63:0]          p1_q;
  logic                 neg_q;
  logic [63:0]          hi_q;
  logic [47:0]          lo_q;
  logic [63:0]          csum_q;
  logic                 sneg_q;
  logic                 rd_ok_q;
  logic                 nw_q;
  logic [31:0]          res_q [wom_pkg::NUM_VAL];
  logic [31:0]          mean_out_q;
  logic [31:0]          cov_out_q [wom_pkg::NUM_VAL];
  logic                 nw_out_q;

  // Divider port.
  logic                            div_start;
  logic [wom_pkg::CUM_W-1:0]       div_rem;
  logic [wom_pkg::SHIFT_W-1:0]     div_bits;
  logic [wom_pkg::ITER_W-1:0]      div_iters;
  logic [wom_pkg::CUM_W-1:0]       div_dvs;
  logic                            div_done;
  logic [wom_pkg::QUOT_W-1:0]      div_quot;

  // Combinational helpers.
  logic [IW-1:0]        r_i, c_i;
  logic                 rd_phase;
  int                   base_row;
  logic [CW-1:0]        xk;
  logic [31:0]          x_val;
  logic [48:0]          tmp49;
  logic [wom_pkg::CUM_W-1:0] tmp;
  logic signed [32:0]   dlt;
  logic [32:0]          dmag;
  logic signed [32:0]   dlt_r;
  logic [32:0]          dmag_r;
  logic signed [32:0]   e_c;
  logic [32:0]          emag;
  logic signed [33:0]   nm34;
  logic [63:0]          m_term, mc_term, term;
  logic [64:0]          s65;
  logic [63:0]          smag;
  logic                 ovf;
  logic [31:0]          q32;
  logic [31:0]          qfix;
  logic                 row_ok;

  assign r_i      = r_q[IW-1:0];
  assign c_i      = c_q[IW-1:0];
  assign rd_phase = state_q inside {wom_pkg::ST_RD_MEAN, wom_pkg::ST_RD_ADDR,
                                    wom_pkg::ST_RD_CHK, wom_pkg::ST_RD_WAIT};
  assign row_ok   = int'(cmd_q.row_index) < STATE_DIM;
  assign base_row = int'(cmd_q.time_index) * STATE_DIM +
                    (rd_phase ? int'(cmd_q.row_index) : int'(r_q));
  assign mean_addr = MAW'(base_row);
  assign cov_addr  = CAW'(base_row * STATE_DIM + int'(c_q));

  // Sample element: elements beyond the inputs read as zero.
  assign xk    = (state_q == wom_pkg::ST_CV_A) ? c_q : r_q;
  assign x_val = (int'(xk) < wom_pkg::NUM_VAL) ? cmd_q.value[2'(xk)] : '0;

  // Saturated cumulative weight including this sample.
  assign tmp49 = {1'b0, cum_q} + 49'(cmd_q.weight);
  assign tmp   = tmp49[48] ? wom_pkg::CUM_MAX : tmp49[47:0];

  // Mean path arithmetic.
  always_comb begin
    dlt   = $signed({x_val[31], x_val}) - $signed({mean_rdata_q[31], mean_rdata_q});
    dmag  = dlt[32] ? 33'(-dlt) : dlt;
    nm34  = dlt_q[r_i][32] ? ($signed({{2{mv_q[31]}}, mv_q}) - $signed({1'b0, div_quot}))
                           : ($signed({{2{mv_q[31]}}, mv_q}) + $signed({1'b0, div_quot}));
  end

  // Covariance term arithmetic.
  always_comb begin
    dlt_r   = dlt_q[r_i];
    dmag_r  = dlt_r[32] ? 33'(-dlt_r) : dlt_r;
    e_c     = $signed({x_val[31], x_val}) - $signed({nm_q[c_i][31], nm_q[c_i]});
    emag    = e_c[32] ? 33'(-e_c) : e_c;
    m_term  = hi_q + 64'(lo_q[47:16]);
    mc_term = m_term[63] ? wom_pkg::SUM_POS_MAX : m_term;
    term    = neg_q ? (64'd0 - mc_term) : mc_term;
    s65     = {csum_q[63], csum_q} + {term[63], term};
    if (s65[64] != s65[63]) begin
      cov_wdata = s65[64] ? wom_pkg::SUM_NEG_MAX : wom_pkg::SUM_POS_MAX;
    end else begin
      cov_wdata = s65[63:0];
    end
    if (state_q == wom_pkg::ST_CLEAR) begin
      cov_wdata = '0;
    end
  end

  // Read path: magnitude, overflow check and signed saturation.
  always_comb begin
    smag = cov_rdata_q[63] ? (64'd0 - cov_rdata_q) : cov_rdata_q;
    ovf  = smag[63:16] >= cum_q;
    q32  = div_quot[31:0];
    if (sneg_q) begin
      qfix = (q32 > wom_pkg::OUT_NEG_MAX) ? wom_pkg::OUT_NEG_MAX : (32'd0 - q32);
    end else begin
      qfix = q32[31] ? wom_pkg::OUT_POS_MAX : q32;
    end
  end

  // Divider operands for the mean step or the read scaling.
  always_comb begin
    if (state_q == wom_pkg::ST_ACC_DIV) begin
      div_rem   = {17'd0, pw_q[63:33]};
      div_bits  = {pw_q[32:0], 31'd0};
      div_iters = wom_pkg::MEAN_ITERS;
      div_dvs   = tmp;
    end else begin
      div_rem   = smag[63:16];
      div_bits  = {smag[15:0], 48'd0};
      div_iters = wom_pkg::READ_ITERS;
      div_dvs   = cum_q;
    end
  end

  wom_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .bits_i     (div_bits),
    .iters_i    (div_iters),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Next state and strobes.
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    div_start  = 1'b0;
    mean_re    = 1'b0;
    mean_we    = 1'b0;
    cov_re     = 1'b0;
    cov_we     = 1'b0;
    mean_waddr = mean_addr;
    cov_waddr  = cov_addr;
    mean_wdata = nm34[31:0];
    case (state_q)
      wom_pkg::ST_CLEAR: begin
        ctl_o.clearing = 1'b1;
        cov_we         = 1'b1;
        cov_waddr      = CAW'(clr_q);
        mean_we        = clr_q < MEAN_END;
        mean_waddr     = MAW'(clr_q);
        mean_wdata     = '0;
        if (clr_q == LAST_CLR) begin
          state_d = wom_pkg::ST_IDLE;
        end
      end
      wom_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          ctl_o.pop = 1'b1;
          case (q_cmd_i.kind)
            wom_pkg::CMD_ACC: state_d = q_cmd_i.in_range ? wom_pkg::ST_ACC_RD
                                                         : wom_pkg::ST_COMMIT;
            wom_pkg::CMD_CLR: state_d = wom_pkg::ST_CLEAR;
            wom_pkg::CMD_RD:  state_d = wom_pkg::ST_RD_MEAN;
            default:          state_d = wom_pkg::ST_IDLE;
          endcase
        end
      end
      wom_pkg::ST_ACC_RD: begin
        mean_re = 1'b1;
        state_d = wom_pkg::ST_ACC_MUL;
      end
      wom_pkg::ST_ACC_MUL: begin
        state_d = wom_pkg::ST_ACC_DIV;
      end
      wom_pkg::ST_ACC_DIV: begin
        div_start = 1'b1;
        state_d   = wom_pkg::ST_ACC_WAIT;
      end
      wom_pkg::ST_ACC_WAIT: begin
        if (div_done) begin
          state_d = wom_pkg::ST_ACC_WR;
        end
      end
      wom_pkg::ST_ACC_WR: begin
        mean_we = 1'b1;
        state_d = (r_q == LAST_IDX) ? wom_pkg::ST_CV_A : wom_pkg::ST_ACC_RD;
      end
      wom_pkg::ST_CV_A: begin
        cov_re  = 1'b1;
        state_d = wom_pkg::ST_CV_B;
      end
      wom_pkg::ST_CV_B: begin
        state_d = wom_pkg::ST_CV_C;
      end
      wom_pkg::ST_CV_C: begin
        cov_we  = 1'b1;
        state_d = (r_q == LAST_IDX && c_q == LAST_IDX) ? wom_pkg::ST_COMMIT
                                                       : wom_pkg::ST_CV_A;
      end
      wom_pkg::ST_COMMIT: begin
        state_d = wom_pkg::ST_IDLE;
      end
      wom_pkg::ST_RD_MEAN: begin
        mean_re = 1'b1;
        if (cum_q == '0 || !cmd_q.in_range || !row_ok) begin
          state_d = wom_pkg::ST_EMIT;
        end else begin
          state_d = wom_pkg::ST_RD_ADDR;
        end
      end
      wom_pkg::ST_RD_ADDR: begin
        cov_re  = 1'b1;
        state_d = wom_pkg::ST_RD_CHK;
      end
      wom_pkg::ST_RD_CHK: begin
        if (ovf) begin
          state_d = (c_q == LAST_COL) ? wom_pkg::ST_EMIT : wom_pkg::ST_RD_ADDR;
        end else begin
          div_start = 1'b1;
          state_d   = wom_pkg::ST_RD_WAIT;
        end
      end
      wom_pkg::ST_RD_WAIT: begin
        if (div_done) begin
          state_d = (c_q == LAST_COL) ? wom_pkg::ST_EMIT : wom_pkg::ST_RD_ADDR;
        end
      end
      wom_pkg::ST_EMIT: begin
        state_d = wom_pkg::ST_IDLE;
      end
      default: begin
        state_d = wom_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wom_pkg::ST_CLEAR;
      r_q     <= '0;
      c_q     <= '0;
      clr_q   <= '0;
      cum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == wom_pkg::ST_EMIT;
      case (state_q)
        wom_pkg::ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          cum_q <= '0;
        end
        wom_pkg::ST_IDLE: begin
          r_q   <= '0;
          c_q   <= '0;
          clr_q <= '0;
        end
        wom_pkg::ST_ACC_WR: begin
          r_q <= (r_q == LAST_IDX) ? '0 : r_q + 1'b1;
        end
        wom_pkg::ST_CV_C: begin
          if (c_q == LAST_IDX) begin
            c_q <= '0;
            r_q <= r_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        wom_pkg::ST_COMMIT: begin
          if (cmd_q.last) begin
            cum_q <= tmp;
          end
        end
        wom_pkg::ST_RD_CHK: begin
          if (ovf) begin
            c_q <= c_q + 1'b1;
          end
        end
        wom_pkg::ST_RD_WAIT: begin
          if (div_done) begin
            c_q <= c_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stores, written at one address and read at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[mean_waddr] <= mean_wdata;
    end
    if (mean_re) begin
      mean_rdata_q <= mean_mem[mean_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cov_we) begin
      cov_mem[cov_waddr] <= cov_wdata;
    end
    if (cov_re) begin
      cov_rdata_q <= cov_mem[cov_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      wom_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          cmd_q <= q_cmd_i;
        end
      end
      wom_pkg::ST_ACC_MUL: begin
        pw_q       <= 64'(dmag[31:0]) * 64'(cmd_q.weight);
        dlt_q[r_i] <= dlt;
        mv_q       <= $signed(mean_rdata_q);
      end
      wom_pkg::ST_ACC_WR: begin
        nm_q[r_i] <= $signed(nm34[31:0]);
      end
      wom_pkg::ST_CV_A: begin
        p1_q  <= 64'(dmag_r[31:0]) * 64'(emag[31:0]);
        neg_q <= dlt_r[32] ^ e_c[32];
      end
      wom_pkg::ST_CV_B: begin
        hi_q   <= 64'(p1_q[63:32]) * 64'(cmd_q.weight);
        lo_q   <= 48'(p1_q[31:16]) * 48'(cmd_q.weight);
        csum_q <= cov_rdata_q;
      end
      wom_pkg::ST_RD_MEAN: begin
        rd_ok_q <= (cum_q != '0) && cmd_q.in_range && row_ok;
        nw_q    <= cum_q == '0;
        for (int k = 0; k < wom_pkg::NUM_VAL; k++) begin
          res_q[k] <= '0;
        end
      end
      wom_pkg::ST_RD_CHK: begin
        sneg_q <= cov_rdata_q[63];
        if (ovf) begin
          res_q[2'(c_q)] <= cov_rdata_q[63] ? wom_pkg::OUT_NEG_MAX : wom_pkg::OUT_POS_MAX;
        end
      end
      wom_pkg::ST_RD_WAIT: begin
        if (div_done) begin
          res_q[2'(c_q)] <= qfix;
        end
      end
      wom_pkg::ST_EMIT: begin
        mean_out_q <= rd_ok_q ? mean_rdata_q : '0;
        nw_out_q   <= nw_q;
        for (int k = 0; k < wom_pkg::NUM_VAL; k++) begin
          cov_out_q[k] <= res_q[k];
        end
      end
      default: begin
      end
    endcase
  end

  assign valid_o      = valid_q;
  assign mean_value_o = $signed(mean_out_q);
  assign cov_0_o      = $signed(cov_out_q[0]);
  assign cov_1_o      = $signed(cov_out_q[1]);
  assign cov_2_o      = $signed(cov_out_q[2]);
  assign cov_3_o      = $signed(cov_out_q[3]);
  assign no_weight_o  = nw_out_q;

endmodule

### src/weighted_online_mean_covariance.sv
`timescale 1ns / 1ps

// Weighted running mean and covariance per time point, Q16.16 fixed point.
// Input: a command transfer completes at a rising edge with start high and
// busy low. mode selects accumulate (one sample column with its weight),
// clear (zero all statistics) or read (one mean element and one covariance
// row of a time point). Accumulates with zero weight and unused modes are
// dropped at the front. A two-entry queue holds commands ahead of execution.
// Output: a read gives one result, shown for exactly one cycle while valid_o
// is high; the receiver cannot stall, so nothing is held back.
// Work at STATE_DIM elements: an accumulate runs the 33-step shared divider
// once per element for the mean step, then one read-modify-write per
// covariance entry (STATE_DIM squared read-modify-writes). A read runs the
// same divider once per covariance column that does not saturate, and goes
// straight to its result when no weight has been accumulated.
// Reset and every clear run a pass over the covariance store of
// TIME_POINTS*STATE_DIM*STATE_DIM entries (1024 at the defaults); busy stays
// high for that pass, and no command is taken.
module weighted_online_mean_covariance #(
  parameter int STATE_DIM   = wom_pkg::STATE_DIM_DEF,
  parameter int TIME_POINTS = wom_pkg::TIME_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [5:0]          time_index_i,
  input  logic [1:0]          row_index_i,
  input  logic [31:0]         weight_i,
  input  logic signed [31:0]  value_0_i,
  input  logic signed [31:0]  value_1_i,
  input  logic signed [31:0]  value_2_i,
  input  logic signed [31:0]  value_3_i,
  input  logic                last_of_sample_i,
  output logic                valid_o,
  output logic signed [31:0]  mean_value_o,
  output logic signed [31:0]  cov_0_o,
  output logic signed [31:0]  cov_1_o,
  output logic signed [31:0]  cov_2_o,
  output logic signed [31:0]  cov_3_o,
  output logic                no_weight_o
);

  wom_pkg::back_ctl_t ctl;
  logic               q_valid;
  wom_pkg::cmd_t      q_cmd;

  // Command intake and queue.
  wom_front #(
    .TIME_POINTS (TIME_POINTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .time_index_i     (time_index_i),
    .row_index_i      (row_index_i),
    .weight_i         (weight_i),
    .value_0_i        (value_0_i),
    .value_1_i        (value_1_i),
    .value_2_i        (value_2_i),
    .value_3_i        (value_3_i),
    .last_of_sample_i (last_of_sample_i),
    .ctl_i            (ctl),
    .q_valid_o        (q_valid),
    .q_cmd_o          (q_cmd)
  );

  // Execution of updates, clears and reads.
  wom_back #(
    .STATE_DIM   (STATE_DIM),
    .TIME_POINTS (TIME_POINTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .ctl_o        (ctl),
    .valid_o      (valid_o),
    .mean_value_o (mean_value_o),
    .cov_0_o      (cov_0_o),
    .cov_1_o      (cov_1_o),
    .cov_2_o      (cov_2_o),
    .cov_3_o      (cov_3_o),
    .no_weight_o  (no_weight_o)
  );

endmodule

### src/wom_chk.sv
`timescale 1ns / 1ps

// Port-level checks of the statistics block.
module wom_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                valid_o,
  input logic signed [31:0]  mean_value_o,
  input logic signed [31:0]  cov_0_o,
  input logic signed [31:0]  cov_1_o,
  input logic signed [31:0]  cov_2_o,
  input logic signed [31:0]  cov_3_o,
  input logic                no_weight_o
);

  // A result without accumulated weight carries only zeros.
  a_no_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && no_weight_o |-> mean_value_o == 0 && cov_0_o == 0 && cov_1_o == 0 &&
                               cov_2_o == 0 && cov_3_o == 0)
    else $error("nonzero result fields with no weight");

  // Every read passes from the emit state back to idle, so strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // The clearing pass after reset keeps the block busy.
  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> busy)
    else $error("command port open during the clearing pass");

endmodule

bind weighted_online_mean_covariance wom_chk u_chk (.*);
